@@ hw/rtl/dbd_pkg.sv @@
// Shared types, constants and register codes for the detection box decoder.
package dbd_pkg;

   localparam int DEF_MAX_CLASSES = 128;
   localparam int DEF_MAX_ANCHORS = 16384;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int VALUE_W = 32;
   localparam int COORD_W = 30;
   localparam int SCORE_W = 31;
   localparam int LABEL_W = 7;
   localparam int ANCHOR_W = 14;
   localparam int POS_W = 8;
   localparam int RSP_DATA_W = 176;

   localparam int EDGE_W = 36;
   localparam int PROD_W = 61;
   localparam int FRAC_SHIFT = 17;
   localparam int ROUND_HALF = 65536;

   localparam logic [VALUE_W-1:0] SCORE_FLOOR = 32'h8000_0000;

   typedef enum logic [2:0] {
      REG_SCORE_THRESHOLD,
      REG_CLASS_COUNT,
      REG_PAD_X,
      REG_PAD_Y,
      REG_SCALE_RATIO,
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } reg_index_type;

   typedef struct packed {
      logic [16:0] score_threshold;
      logic [7:0]  class_count;
      logic [28:0] pad_x;
      logic [28:0] pad_y;
      logic [23:0] scale_ratio;
      logic [13:0] image_width;
      logic [13:0] image_height;
   } csr_regs_type;

   localparam csr_regs_type CSR_RESET = '{
      score_threshold: 17'd16384,
      class_count:     8'd80,
      pad_x:           29'd0,
      pad_y:           29'd0,
      scale_ratio:     24'd65536,
      image_width:     14'd640,
      image_height:    14'd640
   };

   typedef struct packed {
      logic [VALUE_W-1:0]  center_x;
      logic [VALUE_W-1:0]  center_y;
      logic [VALUE_W-1:0]  size_w;
      logic [VALUE_W-1:0]  size_h;
      logic [VALUE_W-1:0]  score;
      logic [LABEL_W-1:0]  label;
      logic [ANCHOR_W-1:0] anchor;
   } row_result_type;

endpackage

@@ hw/rtl/detection_box_decode.sv @@
// After its last class score, a box passes the s1, edge, prod, corner and output registers.
// One input beat per cycle unless the box pipe stalls; rows are at least five beats long.
// Four pipeline stages and the output register hold boxes while the result side stalls.
// Reset is synchronous; it restores register defaults and clears the row and anchor state.
// Box value storage has no reset and is always written before it is read.
module detection_box_decode import dbd_pkg::*; #(
   parameter int MAX_CLASSES = DEF_MAX_CLASSES,
   parameter int MAX_ANCHORS = DEF_MAX_ANCHORS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // value
   input  logic [0:0]            req_tuser,   // frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // box_left, box_top, box_width, box_height, best_score, class_label, anchor_index
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   csr_regs_type   regs;
   row_result_type row_result;
   logic           row_done;
   logic           pipe_ready;
   logic           beat_valid;

   assign req_tready = pipe_ready;
   assign beat_valid = req_tvalid && pipe_ready;

   dbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   dbd_row_scan #(
      .MAX_CLASSES (MAX_CLASSES),
      .MAX_ANCHORS (MAX_ANCHORS)
   ) u_row_scan (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (beat_valid),
      .value       (req_tdata),
      .frame_start (req_tuser[0]),
      .class_count (regs.class_count),
      .row_done    (row_done),
      .result      (row_result)
   );

   dbd_box_pipe u_box_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (row_done),
      .in_ready   (pipe_ready),
      .in_data    (row_result),
      .regs       (regs),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hw/rtl/dbd_csr.sv @@
// Configuration register file with an APB-style access port.
module dbd_csr import dbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output csr_regs_type          regs
);

   csr_regs_type  regs_ff;
   csr_regs_type  regs_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         case (index)
            REG_SCORE_THRESHOLD: regs_in.score_threshold = csr_pwdata[16:0];
            REG_CLASS_COUNT:     regs_in.class_count     = csr_pwdata[7:0];
            REG_PAD_X:           regs_in.pad_x           = csr_pwdata[28:0];
            REG_PAD_Y:           regs_in.pad_y           = csr_pwdata[28:0];
            REG_SCALE_RATIO:     regs_in.scale_ratio     = csr_pwdata[23:0];
            REG_IMAGE_WIDTH:     regs_in.image_width     = csr_pwdata[13:0];
            REG_IMAGE_HEIGHT:    regs_in.image_height    = csr_pwdata[13:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SCORE_THRESHOLD: csr_prdata = CSR_DATA_W'(regs_ff.score_threshold);
         REG_CLASS_COUNT:     csr_prdata = CSR_DATA_W'(regs_ff.class_count);
         REG_PAD_X:           csr_prdata = CSR_DATA_W'(regs_ff.pad_x);
         REG_PAD_Y:           csr_prdata = CSR_DATA_W'(regs_ff.pad_y);
         REG_SCALE_RATIO:     csr_prdata = CSR_DATA_W'(regs_ff.scale_ratio);
         REG_IMAGE_WIDTH:     csr_prdata = CSR_DATA_W'(regs_ff.image_width);
         REG_IMAGE_HEIGHT:    csr_prdata = CSR_DATA_W'(regs_ff.image_height);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= CSR_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

@@ hw/rtl/dbd_row_scan.sv @@
// Row tracker: captures the box values and keeps the running maximum score.
module dbd_row_scan import dbd_pkg::*; #(
   parameter int MAX_CLASSES = DEF_MAX_CLASSES,
   parameter int MAX_ANCHORS = DEF_MAX_ANCHORS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               beat_valid,
   input  logic [VALUE_W-1:0] value,
   input  logic               frame_start,
   input  logic [7:0]         class_count,
   output logic               row_done,
   output row_result_type     result
);

   localparam int AnchorWidth = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
   localparam logic [AnchorWidth-1:0] AnchorLast = AnchorWidth'(MAX_ANCHORS - 1);
   localparam logic [POS_W-1:0] ClassLimit = POS_W'(MAX_CLASSES);

   logic [POS_W-1:0]       pos_ff, pos_in, pos_eff;
   logic [VALUE_W-1:0]     max_ff, max_in, max_eff, max_new;
   logic [LABEL_W-1:0]     label_ff, label_in, label_eff, label_new;
   logic [AnchorWidth-1:0] anchor_ff, anchor_in, anchor_eff, anchor_next;
   logic [VALUE_W-1:0]     box_ff [4];
   logic [POS_W-1:0]       class_total;
   logic [LABEL_W-1:0]     cls;
   logic                   in_box;
   logic                   take;
   logic                   last;

   always_comb begin
      pos_eff    = frame_start ? '0 : pos_ff;
      max_eff    = frame_start ? SCORE_FLOOR : max_ff;
      label_eff  = frame_start ? '0 : label_ff;
      anchor_eff = frame_start ? '0 : anchor_ff;

      if (class_count == '0) begin
         class_total = POS_W'(1);
      end else if (class_count > ClassLimit) begin
         class_total = ClassLimit;
      end else begin
         class_total = class_count;
      end

      in_box      = (pos_eff[POS_W-1:2] == '0);
      cls         = LABEL_W'(pos_eff - POS_W'(4));
      take        = (cls == '0) || ($signed(value) > $signed(max_eff));
      max_new     = take ? value : max_eff;
      label_new   = take ? cls : label_eff;
      last        = !in_box && ((POS_W'(cls) + POS_W'(1)) >= class_total);
      anchor_next = (anchor_eff == AnchorLast) ? '0 : anchor_eff + AnchorWidth'(1);
   end

   always_comb begin
      pos_in    = pos_ff;
      max_in    = max_ff;
      label_in  = label_ff;
      anchor_in = anchor_ff;
      if (beat_valid) begin
         if (in_box) begin
            pos_in    = pos_eff + POS_W'(1);
            max_in    = max_eff;
            label_in  = label_eff;
            anchor_in = anchor_eff;
         end else if (last) begin
            pos_in    = '0;
            max_in    = SCORE_FLOOR;
            label_in  = '0;
            anchor_in = anchor_next;
         end else begin
            pos_in    = pos_eff + POS_W'(1);
            max_in    = max_new;
            label_in  = label_new;
            anchor_in = anchor_eff;
         end
      end
   end

   assign row_done        = beat_valid && last;
   assign result.center_x = box_ff[0];
   assign result.center_y = box_ff[1];
   assign result.size_w   = box_ff[2];
   assign result.size_h   = box_ff[3];
   assign result.score    = max_new;
   assign result.label    = label_new;
   assign result.anchor   = ANCHOR_W'(anchor_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         max_ff    <= SCORE_FLOOR;
         label_ff  <= '0;
         anchor_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         max_ff    <= max_in;
         label_ff  <= label_in;
         anchor_ff <= anchor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_valid && in_box) begin
         box_ff[pos_eff[1:0]] <= value;
      end
   end

endmodule

@@ hw/rtl/dbd_box_pipe.sv @@
// Box pipeline: threshold test, corner forming, scaling, rounding, clamping and output.
module dbd_box_pipe import dbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  row_result_type        in_data,
   input  csr_regs_type          regs,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [LABEL_W-1:0]  label;
      logic [ANCHOR_W-1:0] anchor;
   } meta_type;

   function automatic logic [COORD_W-1:0] make_corner(
      input logic signed [PROD_W-1:0] prod,
      input logic [13:0]              size_px
   );
      logic [PROD_W-1:0]            sum;
      logic [PROD_W-FRAC_SHIFT-1:0] rounded;
      logic [COORD_W-1:0]           bound;
      sum     = prod + PROD_W'(ROUND_HALF);
      rounded = sum[PROD_W-1:FRAC_SHIFT];
      bound   = {size_px, 16'd0};
      if (prod[PROD_W-1] || (prod == '0)) begin
         make_corner = '0;
      end else if (rounded > (PROD_W-FRAC_SHIFT)'(bound)) begin
         make_corner = bound;
      end else begin
         make_corner = rounded[COORD_W-1:0];
      end
   endfunction

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic                     rdy1, rdy2, rdy3, rdy4, rdy5;
   row_result_type           s1_ff;
   logic signed [EDGE_W-1:0] edge_ff [4];
   logic signed [EDGE_W-1:0] edge_in [4];
   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [PROD_W-1:0] prod_in [4];
   logic [COORD_W-1:0]       corner_ff [4];
   logic [COORD_W-1:0]       corner_in [4];
   meta_type                 meta2_ff, meta2_in, meta3_ff, meta4_ff;
   logic [RSP_DATA_W-1:0]    tdata_ff, tdata_in;
   logic signed [EDGE_W-1:0] cx, cy, sw, sh;
   logic [COORD_W-1:0]       box_w, box_h;
   logic                     above;

   assign rdy5     = !out_valid_ff || rsp_tready;
   assign rdy4     = !s4_valid_ff || rdy5;
   assign rdy3     = !s3_valid_ff || rdy4;
   assign rdy2     = !s2_valid_ff || rdy3;
   assign rdy1     = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      cx = $signed({{(EDGE_W-VALUE_W){s1_ff.center_x[VALUE_W-1]}}, s1_ff.center_x})
         - $signed({7'd0, regs.pad_x});
      cy = $signed({{(EDGE_W-VALUE_W){s1_ff.center_y[VALUE_W-1]}}, s1_ff.center_y})
         - $signed({7'd0, regs.pad_y});
      sw = $signed({{(EDGE_W-VALUE_W){s1_ff.size_w[VALUE_W-1]}}, s1_ff.size_w});
      sh = $signed({{(EDGE_W-VALUE_W){s1_ff.size_h[VALUE_W-1]}}, s1_ff.size_h});
      edge_in[0] = (cx <<< 1) - sw;
      edge_in[1] = (cx <<< 1) + sw;
      edge_in[2] = (cy <<< 1) - sh;
      edge_in[3] = (cy <<< 1) + sh;
      above = !s1_ff.score[VALUE_W-1]
         && (s1_ff.score[SCORE_W-1:0] > SCORE_W'(regs.score_threshold));
      meta2_in.score  = s1_ff.score[SCORE_W-1:0];
      meta2_in.label  = s1_ff.label;
      meta2_in.anchor = s1_ff.anchor;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = edge_ff[i] * $signed({1'b0, regs.scale_ratio});
      end
   end

   always_comb begin
      corner_in[0] = make_corner(prod_ff[0], regs.image_width);
      corner_in[1] = make_corner(prod_ff[1], regs.image_width);
      corner_in[2] = make_corner(prod_ff[2], regs.image_height);
      corner_in[3] = make_corner(prod_ff[3], regs.image_height);
   end

   always_comb begin
      box_w    = (corner_ff[1] > corner_ff[0]) ? corner_ff[1] - corner_ff[0] : '0;
      box_h    = (corner_ff[3] > corner_ff[2]) ? corner_ff[3] - corner_ff[2] : '0;
      tdata_in = {4'd0, meta4_ff.anchor, meta4_ff.label, meta4_ff.score,
                  box_h, box_w, corner_ff[2], corner_ff[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= in_valid;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff && above;
         end
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rdy4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (rdy5) begin
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= in_data;
      end
      if (rdy2) begin
         edge_ff  <= edge_in;
         meta2_ff <= meta2_in;
      end
      if (rdy3) begin
         prod_ff  <= prod_in;
         meta3_ff <= meta2_ff;
      end
      if (rdy4) begin
         corner_ff <= corner_in;
         meta4_ff  <= meta3_ff;
      end
      if (rdy5) begin
         tdata_ff <= tdata_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = tdata_ff;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the detection box decoder: random rows, stalls and register sweeps.
`timescale 1ns / 1ps

module tb_top import dbd_pkg::*; ();

   typedef struct packed {
      logic [ANCHOR_W-1:0] anchor;
      logic [LABEL_W-1:0]  label;
      logic [SCORE_W-1:0]  score;
      logic [COORD_W-1:0]  height;
      logic [COORD_W-1:0]  width;
      logic [COORD_W-1:0]  top;
      logic [COORD_W-1:0]  left;
   } box_type;

   class box_scoreboard;
      csr_regs_type regs;
      int           row_pos;
      int           box_vals[4];
      int           best;
      int           best_class;
      int           anchor_count;
      int           errors;
      box_type      pending_boxes[$];

      function new();
         regs = CSR_RESET;
         anchor_count = 0;
         errors = 0;
         clear_row();
      endfunction

      function void clear_row();
         row_pos = 0;
         best = int'(SCORE_FLOOR);
         best_class = 0;
      endfunction

      function int effective_classes();
         if (regs.class_count == 0) return 1;
         if (regs.class_count > DEF_MAX_CLASSES) return DEF_MAX_CLASSES;
         return int'(regs.class_count);
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] val);
         case (idx)
            REG_SCORE_THRESHOLD: regs.score_threshold = val[16:0];
            REG_CLASS_COUNT:     regs.class_count = val[7:0];
            REG_PAD_X:           regs.pad_x = val[28:0];
            REG_PAD_Y:           regs.pad_y = val[28:0];
            REG_SCALE_RATIO:     regs.scale_ratio = val[23:0];
            REG_IMAGE_WIDTH:     regs.image_width = val[13:0];
            REG_IMAGE_HEIGHT:    regs.image_height = val[13:0];
            default: ;
         endcase
      endfunction

      // Rounds a doubled corner times the ratio to Q14.16 and clamps it to the image.
      function logic [COORD_W-1:0] corner(longint twice_pos, logic [13:0] size_px);
         longint prod;
         longint bound;
         longint r;
         prod = twice_pos * longint'(regs.scale_ratio);
         bound = longint'(size_px) << 16;
         if (prod <= 0) return '0;
         r = (prod + ROUND_HALF) >>> FRAC_SHIFT;
         if (r > bound) r = bound;
         return r[COORD_W-1:0];
      endfunction

      function void note_value(logic [31:0] v, bit frame_start);
         int      sv;
         int      cls;
         longint  cx;
         longint  cy;
         longint  bw;
         longint  bh;
         box_type b;
         logic [COORD_W-1:0] x0, x1, y0, y1;
         sv = v;
         if (frame_start) begin
            clear_row();
            anchor_count = 0;
         end
         if (row_pos < 4) begin
            box_vals[row_pos] = sv;
            row_pos++;
            return;
         end
         cls = row_pos - 4;
         if (cls == 0 || sv > best) begin
            best = sv;
            best_class = cls;
         end
         row_pos++;
         if (cls + 1 < effective_classes()) return;
         if (longint'(best) > longint'(regs.score_threshold)) begin
            cx = longint'(box_vals[0]) - longint'(regs.pad_x);
            cy = longint'(box_vals[1]) - longint'(regs.pad_y);
            bw = longint'(box_vals[2]);
            bh = longint'(box_vals[3]);
            x0 = corner(2 * cx - bw, regs.image_width);
            x1 = corner(2 * cx + bw, regs.image_width);
            y0 = corner(2 * cy - bh, regs.image_height);
            y1 = corner(2 * cy + bh, regs.image_height);
            b.left = x0;
            b.top = y0;
            b.width = (x1 > x0) ? x1 - x0 : '0;
            b.height = (y1 > y0) ? y1 - y0 : '0;
            b.score = best[SCORE_W-1:0];
            b.label = best_class[LABEL_W-1:0];
            b.anchor = anchor_count[ANCHOR_W-1:0];
            pending_boxes.insert(pending_boxes.size(), b);
         end
         clear_row();
         anchor_count = (anchor_count + 1) % DEF_MAX_ANCHORS;
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_box(logic [RSP_DATA_W-1:0] data);
         box_type want;
         box_type got;
         got = data[$bits(box_type)-1:0];
         if (pending_boxes.size() == 0) begin
            $error("box beat with no box expected: %0h", data);
            errors++;
            return;
         end
         want = pending_boxes.pop_front();
         check_field("box_left", 32'(want.left), 32'(got.left));
         check_field("box_top", 32'(want.top), 32'(got.top));
         check_field("box_width", 32'(want.width), 32'(got.width));
         check_field("box_height", 32'(want.height), 32'(got.height));
         check_field("best_score", 32'(want.score), 32'(got.score));
         check_field("class_label", 32'(want.label), 32'(got.label));
         check_field("anchor_index", 32'(want.anchor), 32'(got.anchor));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata = '0;   // value
   logic [0:0]            req_tuser = '0;   // frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // box_left, box_top, box_width, box_height, best_score, class_label, anchor_index
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   box_scoreboard sb = new();
   bit            source_quiet = 1'b0;
   bit            sink_quiet = 1'b0;
   bit            sender_burst = 1'b0;
   int            hold_cycles = 0;
   int            beats_sent = 0;

   detection_box_decode u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int draw_gap(inout bit quiet);
      if ($urandom_range(0, 31) == 0) quiet = !quiet;
      return quiet ? 0 : int'($urandom_range(0, 17));
   endfunction

   function automatic logic [31:0] rand_center();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(0, 700 << 16);
      endcase
   endfunction

   function automatic logic [31:0] rand_size();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'd0 - $urandom_range(1, 50 << 16);
         default: return $urandom_range(0, 400 << 16);
      endcase
   endfunction

   task automatic send_value(input logic [31:0] v, input bit frame_start);
      int gap;
      gap = sender_burst ? 0 : draw_gap(source_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      req_tuser <= frame_start;
      do @(posedge clock); while (!req_tready);
      sb.note_value(v, frame_start);
      beats_sent++;
   endtask

   task automatic send_box(input logic [31:0] cx, cy, bw, bh, input bit frame_start);
      send_value(cx, frame_start);
      send_value(cy, 1'b0);
      send_value(bw, 1'b0);
      send_value(bh, 1'b0);
   endtask

   task automatic send_row(input bit frame_start);
      int          i;
      int          style;
      logic [31:0] base;
      logic [31:0] s;
      style = $urandom_range(0, 5);
      base = $urandom_range(0, 131072);
      send_box(rand_center(), rand_center(), rand_size(), rand_size(), frame_start);
      for (i = 0; i < sb.effective_classes(); i++) begin
         case (style)
            0: s = $urandom;
            1: s = base - (($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
            default: s = $urandom_range(0, 196608) - 32768;
         endcase
         send_value(s, 1'b0);
      end
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] thr, cc, px, py, ratio, iw, ih);
      csr_write(REG_SCORE_THRESHOLD, thr);
      csr_write(REG_CLASS_COUNT, cc);
      csr_write(REG_PAD_X, px);
      csr_write(REG_PAD_Y, py);
      csr_write(REG_SCALE_RATIO, ratio);
      csr_write(REG_IMAGE_WIDTH, iw);
      csr_write(REG_IMAGE_HEIGHT, ih);
   endtask

   function automatic logic [31:0] pick_image();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd8192;
         3: return 32'd16383;
         default: return $urandom_range(1, 4000);
      endcase
   endfunction

   function automatic logic [31:0] pick_pad();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'h1FFF_FFFF;
         2: return 32'h1000_0000;
         default: return $urandom_range(0, 100 << 16);
      endcase
   endfunction

   task automatic pick_config();
      logic [31:0] thr;
      logic [31:0] cc;
      logic [31:0] ratio;
      case ($urandom_range(0, 5))
         0: thr = 32'd0;
         1: thr = 32'd65536;
         2: thr = 32'h1_FFFF;
         default: thr = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 9))
         0: cc = 32'd0;
         1: cc = 32'd128;
         2: cc = $urandom_range(129, 255);
         3: cc = 32'd80;
         default: cc = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 7))
         0: ratio = 32'd0;
         1: ratio = 32'hFF_FFFF;
         2: ratio = 32'd65536;
         default: ratio = $urandom_range(32'h4000, 32'h4_0000);
      endcase
      write_all(thr, cc, pick_pad(), pick_pad(), ratio, pick_image(), pick_image());
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_boxes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = draw_gap(sink_quiet);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_box(rsp_tdata);
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int  i;
      int  k;
      int  goal;
      int  phase_end;
      bit  first;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults after reset.
      for (i = 0; i < 3; i++) send_row(i == 0);
      wait_idle();

      write_all(0, 1, 0, 0, 65536, 640, 640);
      send_box(320 << 16, 240 << 16, 100 << 16, 50 << 16, 1'b1);
      send_value(32'd1, 1'b0);
      send_box(320 << 16, 240 << 16, 100 << 16, 50 << 16, 1'b0);
      send_value(32'd0, 1'b0);
      send_box(100 << 16, 100 << 16, 32'hFFD8_0000, 20 << 16, 1'b0);
      send_value(32'd65536, 1'b0);
      send_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_value(32'h7FFF_FFFF, 1'b0);
      wait_idle();

      write_all(0, 3, 16 << 16, 8 << 16, 32'hFF_FFFF, 8192, 8192);
      send_box(200 << 16, 200 << 16, 30 << 16, 30 << 16, 1'b0);
      for (i = 0; i < 3; i++) send_value(32'd5, 1'b0);
      send_box(200 << 16, 200 << 16, 30 << 16, 30 << 16, 1'b0);
      for (i = 0; i < 3; i++) send_value(32'h8000_0000, 1'b0);
      send_value(32'd7 << 16, 1'b0);
      send_value(32'd9 << 16, 1'b1);
      send_box(50 << 16, 60 << 16, 10 << 16, 12 << 16, 1'b1);
      send_value(32'd1, 1'b0);
      send_value(32'd9, 1'b0);
      send_value(32'd9, 1'b0);
      wait_idle();

      write_all(0, 0, 0, 0, 65536, 0, 16383);
      send_box(10 << 16, 10 << 16, 4 << 16, 4 << 16, 1'b0);
      send_value(32'd100, 1'b0);
      wait_idle();

      // The sink stalls for a long stretch while rows keep coming back to back.
      write_all(0, 1, 0, 0, 65536, 640, 640);
      sender_burst = 1'b1;
      hold_cycles = 200;
      for (i = 0; i < 60; i++) begin
         send_box(rand_center(), rand_center(), rand_size(), rand_size(), i == 0);
         send_value($urandom_range(1, 32'h7FFF_FFFF), 1'b0);
      end
      sender_burst = 1'b0;
      wait_idle();

      goal = beats_sent + 150;
      while (beats_sent < goal) begin
         pick_config();
         phase_end = beats_sent + 90;
         first = 1'b1;
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 19) == 0) begin
               k = $urandom_range(1, 6);
               for (i = 0; i < k; i++) send_value($urandom, $urandom_range(0, 3) == 0);
               first = 1'b1;
            end else begin
               send_row(first || $urandom_range(0, 15) == 0);
               first = 1'b0;
            end
         end
         wait_idle();
      end

      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
